// File: sv/msbs_pkg.sv
// Shared types and constants for the masked byte signature scanner.
// Used by msbs_match and masked_byte_signature_scan_top; no dependencies.
package msbs_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int OFFSET_BITS       = 32;

    localparam int WINDOW_BITS  = MAX_PATTERN_BYTES * 8;
    localparam int PATTERN_REGS = 4;
    localparam int LEN_BITS     = 6;
    localparam int RESULT_BITS  = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_0_7   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_8_15  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_16_23 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_24_31 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_CARE_MASK     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LEN   = 3'd5;

    typedef struct packed {
        logic [PATTERN_REGS*64-1:0] pattern;        // byte i at bits 8i+7:8i
        logic [31:0]                care_mask;
        logic [LEN_BITS-1:0]        pattern_length;
    } cfg_t;

endpackage

// File: sv/msbs_match.sv
// Masked compare of the byte window against the pattern, aligned to the pattern length.
// Depends on msbs_pkg (cfg_t, MAX_PATTERN_BYTES, WINDOW_BITS).
module msbs_match (
    input  logic [msbs_pkg::WINDOW_BITS-1:0] window,     // newest byte in bits 7:0
    input  msbs_pkg::cfg_t                   cfg,
    output logic                             match
);

    localparam int NB = msbs_pkg::MAX_PATTERN_BYTES;
    localparam logic [6:0] NB_W = 7'(NB);

    logic [msbs_pkg::WINDOW_BITS-1:0] rev_pat;
    logic [msbs_pkg::WINDOW_BITS-1:0] pat_aligned;
    logic [NB-1:0]                    rev_mask;
    logic [NB-1:0]                    mask_aligned;
    logic [6:0]                       shift_bytes;
    logic [NB-1:0]                    byte_ok;

    // Pattern byte len-1-j lines up with window byte j: reverse, then shift down.
    always_comb begin
        for (int k = 0; k < NB; k++) begin
            rev_pat[8*k +: 8] = cfg.pattern[8*(NB-1-k) +: 8];
            rev_mask[k]       = cfg.care_mask[NB-1-k];
        end
    end

    assign shift_bytes  = NB_W - {1'b0, cfg.pattern_length};
    assign pat_aligned  = rev_pat >> {shift_bytes, 3'b000};
    assign mask_aligned = rev_mask >> shift_bytes;

    always_comb begin
        for (int j = 0; j < NB; j++) begin
            byte_ok[j] = !mask_aligned[j] || (window[8*j +: 8] == pat_aligned[8*j +: 8]);
        end
    end

    assign match = &byte_ok;

endmodule

// File: sv/masked_byte_signature_scan_top.sv
// Top level of the masked byte signature scanner: stream ports, configuration
// registers and the region state. Depends on msbs_pkg and msbs_match.
//
// The block takes one byte of a region per transfer and finds the first offset
// at which the pattern matches, comparing only the bytes whose care mask bit is
// set. One result comes per region: found with the start offset, or not-found
// on the last byte; bytes after a match give nothing. A pattern length of zero
// matches at offset zero; a length above 32 never matches. The byte counter
// saturates at its maximum. Each byte is registered on input and compared with
// the whole window combinationally into the output register, so a byte can be
// taken every cycle while results are taken; a result is registered once the
// output register is free. While a result waits on m_tready, one byte more can
// enter the input register; then s_tready stays low until the result is taken.
// The user must write configuration only while the block is idle (not enforced).
module masked_byte_signature_scan_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input bytes
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,     // [7:0] data_byte
    input  logic                               s_tlast,     // last_byte
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata,     // [0] found, [32:1] match_offset
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [msbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [msbs_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int OB = msbs_pkg::OFFSET_BITS;
    localparam int NB = msbs_pkg::MAX_PATTERN_BYTES;
    localparam int WB = msbs_pkg::WINDOW_BITS;
    localparam logic [OB-1:0] SEEN_MAX = '1;
    localparam logic [6:0]    NB_W     = 7'(NB);

    // configuration
    logic [63:0]                     pat0_reg, pat1_reg, pat2_reg, pat3_reg;
    logic [31:0]                     care_mask_reg;
    logic [msbs_pkg::LEN_BITS-1:0]   len_reg;
    msbs_pkg::cfg_t                  cfg;

    // input stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // region state
    logic [WB-1:0] window_reg, window_next;
    logic [OB-1:0] seen_reg, seen_next;
    logic          reported_reg, reported_next;

    // output stage
    logic                               m_valid_reg, m_valid_next;
    logic                               found_reg, found_next;
    logic [msbs_pkg::RESULT_BITS-1:0]   offset_reg, offset_next;

    logic                               fire;
    logic [WB-1:0]                      win_shift;
    logic [OB-1:0]                      seen_inc;
    logic [OB-1:0]                      len_ext;
    logic [OB-1:0]                      diff_wide;
    logic                               len_zero, len_ok, seen_ge, window_match;
    logic                               res_valid, res_found;
    logic [msbs_pkg::RESULT_BITS-1:0]   res_offset;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat0_reg      <= '0;
            pat1_reg      <= '0;
            pat2_reg      <= '0;
            pat3_reg      <= '0;
            care_mask_reg <= '0;
            len_reg       <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                msbs_pkg::REG_PATTERN_0_7:   pat0_reg      <= cfg_data;
                msbs_pkg::REG_PATTERN_8_15:  pat1_reg      <= cfg_data;
                msbs_pkg::REG_PATTERN_16_23: pat2_reg      <= cfg_data;
                msbs_pkg::REG_PATTERN_24_31: pat3_reg      <= cfg_data;
                msbs_pkg::REG_CARE_MASK:     care_mask_reg <= cfg_data[31:0];
                msbs_pkg::REG_PATTERN_LEN:   len_reg       <= cfg_data[msbs_pkg::LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.pattern        = {pat3_reg, pat2_reg, pat1_reg, pat0_reg};
    assign cfg.care_mask      = care_mask_reg;
    assign cfg.pattern_length = len_reg;

    // Advance the input stage whenever the output register is free or being drained.
    assign fire          = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready      = !in_valid_reg || fire;
    assign in_valid_next = s_tvalid ? 1'b1 : (in_valid_reg && !fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    assign win_shift = {window_reg[WB-9:0], in_byte_reg};
    assign seen_inc  = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + OB'(1);
    assign len_ext   = OB'(len_reg);
    assign len_zero  = (len_reg == '0);
    assign len_ok    = ({1'b0, len_reg} <= NB_W);
    assign seen_ge   = (seen_inc >= len_ext);
    assign diff_wide = seen_inc - len_ext;

    msbs_match u_match (
        .window (win_shift),
        .cfg    (cfg),
        .match  (window_match)
    );

    always_comb begin
        res_valid  = 1'b0;
        res_found  = 1'b0;
        res_offset = '0;
        if (!reported_reg) begin
            priority if (len_zero) begin
                res_valid = 1'b1;
                res_found = 1'b1;
            end else if (len_ok && seen_ge && window_match) begin
                res_valid  = 1'b1;
                res_found  = 1'b1;
                res_offset = diff_wide[msbs_pkg::RESULT_BITS-1:0];
            end else if (in_last_reg) begin
                res_valid = 1'b1;
            end
        end
    end

    always_comb begin
        window_next   = window_reg;
        seen_next     = seen_reg;
        reported_next = reported_reg;
        if (fire) begin
            if (in_last_reg) begin
                window_next   = '0;
                seen_next     = '0;
                reported_next = 1'b0;
            end else if (!reported_reg) begin
                window_next   = win_shift;
                seen_next     = seen_inc;
                reported_next = res_found;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= '0;
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end else begin
            window_reg   <= window_next;
            seen_reg     <= seen_next;
            reported_reg <= reported_next;
        end
    end

    // Hold the result until the downstream transfer completes.
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        found_next   = found_reg;
        offset_next  = offset_reg;
        if (fire) begin
            m_valid_next = res_valid;
            found_next   = res_found;
            offset_next  = res_offset;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg  <= found_next;
        offset_reg <= offset_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, offset_reg, found_reg};

endmodule
